FILE: hdl/bmma_pkg.sv
// Package for the block mean moving average and peak-to-peak detector.
// Holds sizing constants, the divide-by-WINDOW reciprocal and shared types.
// No dependencies; the other files except bmma_ram refer to it by scoped names.
`timescale 1ns / 1ps

package bmma_pkg;

  // Sizing of the block and the averaging window
  localparam int BLOCK  = 1024;
  localparam int WINDOW = 5;

  localparam int SAMPLE_W   = 12;
  localparam int SAMPLE_MAX = 4095;
  localparam int MEAN_W     = 22;

  localparam longint unsigned SUM_MAX   = longint'(SAMPLE_MAX) * BLOCK;
  localparam longint unsigned TOTAL_MAX = SUM_MAX * WINDOW;

  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int TOTAL_W = $clog2(TOTAL_MAX + 1);
  localparam int COUNT_W = (BLOCK > 1) ? $clog2(BLOCK) : 1;
  localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Truncating divide by WINDOW as multiply by a rounded-up reciprocal
  localparam int RECIP_SHIFT = TOTAL_W + $clog2(WINDOW);
  localparam longint unsigned RECIP =
    ((longint'(1) << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int PROD_A = 2 * TOTAL_W + 1;
  localparam int PROD_B = RECIP_SHIFT + MEAN_W;
  localparam int PROD_W = (PROD_A > PROD_B) ? PROD_A : PROD_B;

  // Finished block, registered in the cycle after its last sample
  typedef struct packed {
    logic                valid;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] p2p;
  } blk_t;

endpackage

FILE: hdl/bmma_in_if.sv
// Sample channel: valid/ready handshake carrying one ADC sample.
// Depends on bmma_pkg for the sample width.
`timescale 1ns / 1ps

interface bmma_in_if;
  logic                          valid;
  logic                          ready;
  logic [bmma_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: hdl/bmma_out_if.sv
// Result channel: valid/ready handshake carrying moving mean and peak-to-peak.
// Depends on bmma_pkg for the field widths.
`timescale 1ns / 1ps

interface bmma_out_if;
  logic                          valid;
  logic                          ready;
  logic [bmma_pkg::MEAN_W-1:0]   moving_mean;
  logic [bmma_pkg::SAMPLE_W-1:0] peak_to_peak;

  modport source (output valid, output moving_mean, output peak_to_peak, input ready);
  modport sink   (input valid, input moving_mean, input peak_to_peak, output ready);
endinterface

FILE: hdl/bmma_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bmma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/bmma_acc.sv
// Per-block accumulator: running sum, minimum, maximum and sample count.
// Emits the finished block in the cycle after its last sample. Uses bmma_pkg.
`timescale 1ns / 1ps

module bmma_acc (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [bmma_pkg::SAMPLE_W-1:0] sample,
  output logic                          at_last,
  output bmma_pkg::blk_t                blk
);

  logic [bmma_pkg::COUNT_W-1:0]  count;
  logic [bmma_pkg::SUM_W-1:0]    sum;
  logic [bmma_pkg::SAMPLE_W-1:0] run_max;
  logic [bmma_pkg::SAMPLE_W-1:0] run_min;

  logic [bmma_pkg::SUM_W-1:0]    sum_next;
  logic [bmma_pkg::SAMPLE_W-1:0] max_next;
  logic [bmma_pkg::SAMPLE_W-1:0] min_next;

  // Next sample closes the block
  assign at_last = (count == bmma_pkg::COUNT_W'(bmma_pkg::BLOCK - 1));

  assign sum_next = sum + bmma_pkg::SUM_W'(sample);
  assign max_next = (sample > run_max) ? sample : run_max;
  assign min_next = (sample < run_min) ? sample : run_min;

  // Running statistics, restarted after the last sample of each block
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      run_max <= '0;
      run_min <= bmma_pkg::SAMPLE_W'(bmma_pkg::SAMPLE_MAX);
    end else if (take) begin
      if (at_last) begin
        count   <= '0;
        sum     <= '0;
        run_max <= '0;
        run_min <= bmma_pkg::SAMPLE_W'(bmma_pkg::SAMPLE_MAX);
      end else begin
        count   <= count + 1'b1;
        sum     <= sum_next;
        run_max <= max_next;
        run_min <= min_next;
      end
    end
  end

  // Finished block hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      blk.valid <= 1'b0;
    end else begin
      blk.valid <= take && at_last;
    end
    if (take && at_last) begin
      blk.sum <= sum_next;
      blk.p2p <= max_next - min_next;
    end
  end

endmodule

FILE: hdl/block_mean_moving_average_peak_detect_top.sv
// Block mean moving average with peak-to-peak detection: one sample per
// cycle in; one result out per BLOCK samples (1024 by default). Each result
// holds the mean of the last WINDOW (5) block means scaled by BLOCK, and the
// largest minus the smallest sample of the block just finished. Samples are
// taken every cycle; the only hold-off is on the last sample of a block,
// which waits until the previous block's result has left the two internal
// stages (the ring read-modify-write and the divide) and found room in the
// output register. A result passes the block, window total and output
// registers after the last sample of its block. The block sums sit in a
// WINDOW-entry RAM with a registered read; entries not yet written since
// reset read as zero through per-entry valid bits, so there is no clearing
// pass. Depends on bmma_pkg, bmma_in_if, bmma_out_if, bmma_ram, bmma_acc.
`timescale 1ns / 1ps

module block_mean_moving_average_peak_detect_top (
  input logic        clk,
  input logic        rst,
  bmma_in_if.sink    sample_ch,
  bmma_out_if.source result_ch
);

  logic                          take;
  logic                          at_last;
  bmma_pkg::blk_t                blk;

  logic [bmma_pkg::POS_W-1:0]    pos;
  logic [bmma_pkg::WINDOW-1:0]   entry_valid;
  logic                          old_valid;
  logic [bmma_pkg::SUM_W-1:0]    rd_data;
  logic [bmma_pkg::SUM_W-1:0]    old_sum;
  logic [bmma_pkg::TOTAL_W-1:0]  window_total;
  logic [bmma_pkg::TOTAL_W-1:0]  total_next;

  logic                          p2_valid;
  logic [bmma_pkg::SAMPLE_W-1:0] p2_p2p;
  logic [bmma_pkg::PROD_W-1:0]   prod;
  logic                          out_free;

  logic                          out_valid;
  logic [bmma_pkg::MEAN_W-1:0]   out_mean;
  logic [bmma_pkg::SAMPLE_W-1:0] out_p2p;

  // Interlock: a block end waits for the previous result to leave the ring update and divide
  assign sample_ch.ready = !at_last || (!blk.valid && !p2_valid);
  assign take            = sample_ch.valid && sample_ch.ready;

  bmma_acc u_acc (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .sample  (sample_ch.sample),
    .at_last (at_last),
    .blk     (blk)
  );

  // Ring of block sums: read at block end, written back in the cycle after
  bmma_ram #(
    .WIDTH (bmma_pkg::SUM_W),
    .DEPTH (bmma_pkg::WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (blk.valid),
    .wr_addr (pos),
    .wr_data (blk.sum),
    .rd_en   (take && at_last),
    .rd_addr (pos),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (take && at_last) begin
      old_valid <= entry_valid[pos];
    end
  end

  assign old_sum    = old_valid ? rd_data : '0;
  assign total_next = window_total - bmma_pkg::TOTAL_W'(old_sum)
                    + bmma_pkg::TOTAL_W'(blk.sum);

  // Window total, ring position and written-entry marks
  always_ff @(posedge clk) begin
    if (rst) begin
      window_total <= '0;
      pos          <= '0;
      entry_valid  <= '0;
    end else if (blk.valid) begin
      window_total     <= total_next;
      entry_valid[pos] <= 1'b1;
      if (pos == bmma_pkg::POS_W'(bmma_pkg::WINDOW - 1)) begin
        pos <= '0;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  // Divide by WINDOW: reciprocal multiply, registered into the output
  assign prod = bmma_pkg::PROD_W'(window_total)
              * bmma_pkg::PROD_W'(bmma_pkg::RECIP);
  assign out_free = !out_valid || result_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (blk.valid) begin
        p2_valid <= 1'b1;
      end else if (p2_valid && out_free) begin
        p2_valid <= 1'b0;
      end
      if (p2_valid && out_free) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (blk.valid) begin
      p2_p2p <= blk.p2p;
    end
    if (p2_valid && out_free) begin
      out_mean <= prod[bmma_pkg::RECIP_SHIFT +: bmma_pkg::MEAN_W];
      out_p2p  <= p2_p2p;
    end
  end

  assign result_ch.valid        = out_valid;
  assign result_ch.moving_mean  = out_mean;
  assign result_ch.peak_to_peak = out_p2p;

endmodule
